// ===== rtl/core/bpt_pkg.sv =====
// Package for the barometric compensation block: widths, constants,
// micro-op encoding and the control structs shared by the sequencer and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bpt_pkg;

    // Field widths
    localparam int RAW_W     = 24;
    localparam int CAL_W     = 16;
    localparam int CAL_WORDS = 6;
    localparam int CFG_IDX_W = 3;
    localparam int DT_W      = 25;
    localparam int TEMP_W    = 19;
    localparam int PRES_W    = 32;

    // Datapath widths
    localparam int MA_W   = 25;
    localparam int MB_W   = 18;
    localparam int PROD_W = MA_W + MB_W;
    localparam int OFF_W  = 35;
    localparam int SENS_W = 35;
    localparam int ACC_W  = 62;
    localparam int STEP_W = 4;

    // Calibration word slots
    localparam logic [CFG_IDX_W-1:0] CAL_C1 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CAL_C2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CAL_C3 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CAL_C4 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CAL_C5 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CAL_C6 = 3'd5;

    // Sample / result kinds
    localparam logic KIND_TEMP = 1'b0;
    localparam logic KIND_PRES = 1'b1;

    localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [0:0] {
        MA_DT,
        MA_RAW
    } mul_a_t;

    typedef enum logic [2:0] {
        MB_C4,
        MB_C3,
        MB_C6,
        MB_SLO,
        MB_SHI
    } mul_b_t;

    typedef enum logic [3:0] {
        ALU_NOP,
        ALU_DT,
        ALU_TEMP_FIN,
        ALU_OFF,
        ALU_SENS,
        ALU_LOAD,
        ALU_ACC,
        ALU_SUB,
        ALU_PRES_FIN
    } alu_op_t;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_BR_PRES,
        SEQ_END
    } seq_op_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } seq_state_t;

    typedef struct packed {
        logic    mul_en;
        mul_a_t  mul_a;
        mul_b_t  mul_b;
        alu_op_t alu_op;
        seq_op_t seq_op;
        step_t   target;
    } uop_t;

    // Sequencer to datapath
    typedef struct packed {
        logic go;    // current micro-op executes this cycle
        logic load;  // sample beat accepted, latch it
        logic emit;  // last step of an item, result goes out
        uop_t uop;
    } ctl_t;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [CAL_W-1:0]     data;
    } cfg_wr_t;

endpackage

`default_nettype wire

// ===== rtl/core/bpt_channels.sv =====
// Valid/ready channel interfaces: sample input, result output, config write.
// Depends on bpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bpt_sample_if import bpt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             opcode;
    logic [RAW_W-1:0] raw_sample;

    modport source (output valid, output opcode, output raw_sample, input ready);
    modport sink   (input valid, input opcode, input raw_sample, output ready);
endinterface

interface bpt_result_if import bpt_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     result_kind;
    logic signed [TEMP_W-1:0] temperature_centi;
    logic signed [PRES_W-1:0] pressure_value;

    modport source (output valid, output result_kind, output temperature_centi,
                    output pressure_value, input ready);
    modport sink   (input valid, input result_kind, input temperature_centi,
                    input pressure_value, output ready);
endinterface

interface bpt_cfg_if import bpt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CAL_W-1:0]     wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bpt_sequencer.sv =====
// Microcode sequencer: step counter, control-store ROM, branch on sample kind.
// Depends on bpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpt_sequencer import bpt_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire logic kind,
    input  wire logic out_busy,
    output ctl_t      ctl,
    output logic      busy
);

    localparam step_t ST_DISPATCH = 4'd0;
    localparam step_t ST_T_DT     = 4'd1;
    localparam step_t ST_T_MUL    = 4'd2;
    localparam step_t ST_T_FIN    = 4'd3;
    localparam step_t ST_P_OFF    = 4'd4;
    localparam step_t ST_P_SENS   = 4'd5;
    localparam step_t ST_P_MLO    = 4'd6;
    localparam step_t ST_P_MHI    = 4'd7;
    localparam step_t ST_P_ACC    = 4'd8;
    localparam step_t ST_P_SUB    = 4'd9;
    localparam step_t ST_P_FIN    = 4'd10;

    // Control store
    function automatic uop_t ucode_rom(input step_t addr);
        uop_t u;
        u.mul_en = 1'b0;
        u.mul_a  = MA_DT;
        u.mul_b  = MB_C4;
        u.alu_op = ALU_NOP;
        u.seq_op = SEQ_NEXT;
        u.target = ST_DISPATCH;
        case (addr)
            ST_DISPATCH:
            begin
                u.mul_en = 1'b1;          // dT*C4, used by the pressure path
                u.seq_op = SEQ_BR_PRES;
                u.target = ST_P_OFF;
            end
            ST_T_DT:     u.alu_op = ALU_DT;
            ST_T_MUL:
            begin
                u.mul_en = 1'b1;
                u.mul_b  = MB_C6;
            end
            ST_T_FIN:
            begin
                u.alu_op = ALU_TEMP_FIN;
                u.seq_op = SEQ_END;
            end
            ST_P_OFF:
            begin
                u.alu_op = ALU_OFF;
                u.mul_en = 1'b1;
                u.mul_b  = MB_C3;
            end
            ST_P_SENS:   u.alu_op = ALU_SENS;
            ST_P_MLO:
            begin
                u.mul_en = 1'b1;
                u.mul_a  = MA_RAW;
                u.mul_b  = MB_SLO;
            end
            ST_P_MHI:
            begin
                u.alu_op = ALU_LOAD;
                u.mul_en = 1'b1;
                u.mul_a  = MA_RAW;
                u.mul_b  = MB_SHI;
            end
            ST_P_ACC:    u.alu_op = ALU_ACC;
            ST_P_SUB:    u.alu_op = ALU_SUB;
            ST_P_FIN:
            begin
                u.alu_op = ALU_PRES_FIN;
                u.seq_op = SEQ_END;
            end
            default:     u.seq_op = SEQ_END;
        endcase
        return u;
    endfunction

    seq_state_t state_reg, state_next;
    step_t      step_reg, step_next;
    uop_t       uop;
    logic       is_end;
    logic       go;
    logic       accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= ST_DISPATCH;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        uop      = ucode_rom(step_reg);
        is_end   = (uop.seq_op == SEQ_END);
        go       = (state_reg == ST_RUN) && !(is_end && out_busy);
        in_ready = (state_reg == ST_IDLE) || (go && is_end);
        accept   = in_valid && in_ready;

        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    step_next  = ST_DISPATCH;
                end
            end
            ST_RUN:
            begin
                if (go)
                begin
                    if (is_end)
                    begin
                        step_next  = ST_DISPATCH;
                        state_next = accept ? ST_RUN : ST_IDLE;
                    end
                    else if (uop.seq_op == SEQ_BR_PRES && kind == KIND_PRES)
                        step_next = uop.target;
                    else
                        step_next = step_t'(step_reg + 1'b1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                step_next  = ST_DISPATCH;
            end
        endcase

        ctl.go   = go;
        ctl.load = accept;
        ctl.emit = go && is_end;
        ctl.uop  = uop;
        busy     = (state_reg == ST_RUN);
    end

endmodule

`default_nettype wire

// ===== rtl/core/bpt_datapath.sv =====
// Datapath: calibration words, shared 25x18 multiplier, accumulator and
// truncating shifts driven by the sequencer's micro-ops. Depends on bpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpt_datapath import bpt_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ctl_t             ctl,
    input  wire cfg_wr_t          cfg,
    input  wire logic             opcode,
    input  wire logic [RAW_W-1:0] raw_sample,
    output logic                  kind,
    output logic signed [TEMP_W-1:0] res_temp,
    output logic signed [PRES_W-1:0] res_pres
);

    localparam logic signed [46:0] PRES_MAX = 47'sd2147483647;
    localparam logic signed [46:0] PRES_MIN = -47'sd2147483648;

    logic [CAL_W-1:0]         cal_reg [CAL_WORDS];
    logic signed [DT_W-1:0]   dt_reg, dt_next;
    logic signed [TEMP_W-1:0] temp_reg;
    logic                     kind_reg;
    logic [RAW_W-1:0]         raw_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [OFF_W-1:0]  off_reg, off_next;
    logic signed [SENS_W-1:0] sens_reg, sens_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic [PROD_W-1:0]        prod_b7, prod_b8, prod_b23;
    logic [ACC_W-1:0]         acc_b15, acc_b21;
    logic signed [40:0]       q21;
    logic signed [46:0]       q15;
    logic signed [TEMP_W-1:0] temp_new;
    logic signed [PRES_W-1:0] pres_sat;

    // Calibration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAL_WORDS; i++)
                cal_reg[i] <= '0;
        end
        else if (cfg.we)
        begin
            for (int i = 0; i < CAL_WORDS; i++)
                if (cfg.idx == CFG_IDX_W'(i))
                    cal_reg[i] <= cfg.data;
        end
    end

    // Operand select
    always_comb
    begin
        case (ctl.uop.mul_a)
            MA_RAW:  mul_a = $signed({1'b0, raw_reg});
            default: mul_a = dt_reg;
        endcase
        case (ctl.uop.mul_b)
            MB_C4:   mul_b = $signed({2'b00, cal_reg[CAL_C4]});
            MB_C3:   mul_b = $signed({2'b00, cal_reg[CAL_C3]});
            MB_C6:   mul_b = $signed({2'b00, cal_reg[CAL_C6]});
            MB_SLO:  mul_b = $signed({1'b0, sens_reg[16:0]});
            MB_SHI:  mul_b = sens_reg[SENS_W-1:17];
            default: mul_b = '0;
        endcase
        prod_next = mul_a * mul_b;
    end

    // Truncating divides by 2^k: bias negatives by 2^k-1, then drop k bits
    always_comb
    begin
        prod_b7  = prod_reg + {{(PROD_W-7){1'b0}}, {7{prod_reg[PROD_W-1]}}};
        prod_b8  = prod_reg + {{(PROD_W-8){1'b0}}, {8{prod_reg[PROD_W-1]}}};
        prod_b23 = prod_reg + {{(PROD_W-23){1'b0}}, {23{prod_reg[PROD_W-1]}}};
        acc_b15  = acc_reg + {{(ACC_W-15){1'b0}}, {15{acc_reg[ACC_W-1]}}};
        acc_b21  = acc_reg + {{(ACC_W-21){1'b0}}, {21{acc_reg[ACC_W-1]}}};
        q21      = $signed(acc_b21[ACC_W-1:21]);
        q15      = $signed(acc_b15[ACC_W-1:15]);

        temp_new = $signed(prod_b23[41:23]) + TEMP_BASE;

        if (q15 > PRES_MAX)
            pres_sat = 32'sh7FFF_FFFF;
        else if (q15 < PRES_MIN)
            pres_sat = 32'sh8000_0000;
        else
            pres_sat = q15[PRES_W-1:0];
    end

    // ALU
    always_comb
    begin
        dt_next   = $signed({1'b0, raw_reg}) - $signed({1'b0, cal_reg[CAL_C5], 8'h00});
        off_next  = $signed({3'b000, cal_reg[CAL_C2], 16'h0000}) + $signed(prod_b7[41:7]);
        sens_next = $signed({4'h0, cal_reg[CAL_C1], 15'h0000}) + $signed(prod_b8[42:8]);
        case (ctl.uop.alu_op)
            ALU_LOAD: acc_next = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
            ALU_ACC:  acc_next = acc_reg
                               + {{(ACC_W-PROD_W-17){prod_reg[PROD_W-1]}}, prod_reg, 17'h0};
            ALU_SUB:  acc_next = {{(ACC_W-41){q21[40]}}, q21}
                               - {{(ACC_W-OFF_W){off_reg[OFF_W-1]}}, off_reg};
            default:  acc_next = acc_reg;
        endcase
    end

    // Stored temperature state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg   <= '0;
            temp_reg <= '0;
        end
        else if (ctl.go)
        begin
            if (ctl.uop.alu_op == ALU_DT)
                dt_reg <= dt_next;
            if (ctl.uop.alu_op == ALU_TEMP_FIN)
                temp_reg <= temp_new;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            kind_reg <= opcode;
            raw_reg  <= raw_sample;
        end
        if (ctl.go)
        begin
            if (ctl.uop.mul_en)
                prod_reg <= prod_next;
            if (ctl.uop.alu_op == ALU_OFF)
                off_reg <= off_next;
            if (ctl.uop.alu_op == ALU_SENS)
                sens_reg <= sens_next;
            acc_reg <= acc_next;
        end
    end

    // Result fields, valid on the emitting step
    always_comb
    begin
        kind     = kind_reg;
        res_temp = (ctl.uop.alu_op == ALU_TEMP_FIN) ? temp_new : temp_reg;
        res_pres = (ctl.uop.alu_op == ALU_PRES_FIN) ? pres_sat : '0;
    end

endmodule

`default_nettype wire

// ===== rtl/core/baro_pressure_temp_compensation_unit.sv =====
// Top level of the barometric compensation block: sequencer, datapath, result register.
// Depends on bpt_pkg, bpt_channels, bpt_sequencer, bpt_datapath.
//
// Usage:
//  - sample_ch (sink): one beat per raw conversion; opcode 0 = temperature,
//    1 = pressure. raw_sample is the unsigned 24-bit reading.
//  - cfg_ch (sink): writes calibration word C1..C6 at reg_index 0..5; always
//    ready, indexes 6 and 7 are dropped. Write only while the block is idle.
//  - result_ch (source): one beat per sample. Temperature beats carry the new
//    temperature and a zero pressure; pressure beats carry the stored
//    temperature and the saturated pressure in pascals.
//  - A sample's microprogram runs to its last step before the next sample is
//    taken; a pressure item runs a longer microprogram than a temperature item,
//    all on the single shared 25x18 multiplier.
//  - Intake happens on the last microcode step of the current item. One result
//    may wait in the output register; if it is still held when the next item
//    reaches its last step, the sequencer and intake stop until it is taken.
//  - Reset clears calibration words, stored dT and temperature, and the
//    sequencer; no result is pending after reset.
`timescale 1ns / 1ps
`default_nettype none

module baro_pressure_temp_compensation_unit import bpt_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    bpt_sample_if.sink   sample_ch,
    bpt_cfg_if.sink      cfg_ch,
    bpt_result_if.source result_ch
);

    ctl_t    ctl;
    cfg_wr_t cfg;
    logic    seq_busy;
    logic    out_busy;
    logic    dp_kind;

    logic signed [TEMP_W-1:0] dp_temp;
    logic signed [PRES_W-1:0] dp_pres;

    // Output register
    logic                     res_valid_reg, res_valid_next;
    logic                     res_kind_reg;
    logic signed [TEMP_W-1:0] res_temp_reg;
    logic signed [PRES_W-1:0] res_pres_reg;

    // Config writes land directly; the port never stalls.
    assign cfg_ch.ready = 1'b1;
    assign cfg.we       = cfg_ch.valid;
    assign cfg.idx      = cfg_ch.reg_index;
    assign cfg.data     = cfg_ch.wr_data;

    // Output slot is blocked when it holds a beat the sink is not taking.
    assign out_busy = res_valid_reg && !result_ch.ready;

    bpt_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_ch.valid),
        .in_ready (sample_ch.ready),
        .kind     (dp_kind),
        .out_busy (out_busy),
        .ctl      (ctl),
        .busy     (seq_busy)
    );

    bpt_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .cfg        (cfg),
        .opcode     (sample_ch.opcode),
        .raw_sample (sample_ch.raw_sample),
        .kind       (dp_kind),
        .res_temp   (dp_temp),
        .res_pres   (dp_pres)
    );

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (ctl.emit)
            res_valid_next = 1'b1;
        else if (res_valid_reg && result_ch.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            res_kind_reg <= dp_kind;
            res_temp_reg <= dp_temp;
            res_pres_reg <= dp_pres;
        end
    end

    assign result_ch.valid             = res_valid_reg;
    assign result_ch.result_kind       = res_kind_reg;
    assign result_ch.temperature_centi = res_temp_reg;
    assign result_ch.pressure_value    = res_pres_reg;

`ifndef SYNTHESIS
    // A taken sample always occupies the sequencer for at least one more step.
    a_no_back_to_back_intake: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_ch.valid && sample_ch.ready) |=> !sample_ch.ready)
        else $error("sample taken while previous item still at its first step");

    // A result beat only appears out of a running microprogram.
    a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_ch.valid) |-> $past(seq_busy))
        else $error("result raised without a running sequence");
`endif

endmodule

`default_nettype wire
